// ===== sv/smss_pkg.sv =====
package smss_pkg;

    // Matrix geometry and element width.
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int CNT_BITS  = 5;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;

    localparam logic [CNT_BITS-1:0] MAX_ROWS_CNT = CNT_BITS'(MAX_ROWS);
    localparam logic [CNT_BITS-1:0] MAX_COLS_CNT = CNT_BITS'(MAX_COLS);

    // Request action codes.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // One request item.
    typedef struct packed {
        logic                         action;
        logic [ROW_BITS-1:0]          row_index;
        logic [COL_BITS-1:0]          col_index;
        logic signed [VALUE_BITS-1:0] value;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                found;
        logic [CNT_BITS-1:0] hit_row;
        logic [CNT_BITS-1:0] hit_col;
    } res_t;

    // Effective matrix size handed to the walker.
    typedef struct packed {
        logic [CNT_BITS-1:0] rows;
        logic [CNT_BITS-1:0] cols;
    } dims_t;

    // Walker sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DONE
    } walk_state_t;

endpackage

// ===== sv/smss_ram.sv =====
module smss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/smss_walker.sv =====
module smss_walker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smss_pkg::dims_t                   dims,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  smss_pkg::req_t                    req_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output smss_pkg::res_t                    res_data,
    output logic                              ram_we,
    output logic [smss_pkg::ADDR_BITS-1:0]    ram_waddr,
    output logic [smss_pkg::VALUE_BITS-1:0]   ram_wdata,
    output logic                              ram_re,
    output logic [smss_pkg::ADDR_BITS-1:0]    ram_raddr,
    input  logic [smss_pkg::VALUE_BITS-1:0]   ram_rdata
);

    import smss_pkg::*;

    walk_state_t                  state_reg, state_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    res_t                         pend_reg, pend_next;
    logic                         res_valid_reg, res_valid_next;
    res_t                         res_data_reg, res_data_next;

    logic                         req_fire;
    logic                         is_search;
    logic                         empty;
    logic signed [VALUE_BITS-1:0] elem;
    logic                         hit;
    logic                         greater;
    logic                         last_col;
    logic                         last_row;
    logic                         res_load;

    // Handshake and decode of the incoming request.
    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign is_search = (req_data.action == ACT_SEARCH);
    assign empty     = (dims.rows == '0) || (dims.cols == '0);

    // The compare unit: one stored element against the key per cycle.
    assign elem     = signed'(ram_rdata);
    assign hit      = (elem == key_reg);
    assign greater  = (elem > key_reg);
    assign last_col = (col_reg == '0);
    assign last_row = (({1'b0, row_reg} + CNT_BITS'(1)) >= dims.rows);

    // The result register is free when empty or being taken this cycle.
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);

    // Element writes go straight to the store when inside the used area.
    assign ram_we    = req_fire && !is_search
                       && ({1'b0, req_data.row_index} < dims.rows)
                       && ({1'b0, req_data.col_index} < dims.cols);
    assign ram_waddr = {req_data.row_index, req_data.col_index};
    assign ram_wdata = req_data.value;

    // Next-state logic of the walk sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && is_search)
                begin
                    state_next = empty ? ST_DONE : ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (hit || (greater && last_col) || (!greater && last_row))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Position, key and pending result updates for each state.
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        key_next  = key_reg;
        pend_next = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && is_search)
                begin
                    // Start at the top-right corner; a miss reports the counts.
                    key_next          = req_data.value;
                    row_next          = '0;
                    col_next          = COL_BITS'(dims.cols - CNT_BITS'(1));
                    pend_next.found   = 1'b0;
                    pend_next.hit_row = dims.rows;
                    pend_next.hit_col = dims.cols;
                end
            end
            ST_STEP:
            begin
                if (hit)
                begin
                    pend_next.found   = 1'b1;
                    pend_next.hit_row = {1'b0, row_reg};
                    pend_next.hit_col = {1'b0, col_reg};
                end
                else if (greater)
                begin
                    if (!last_col)
                    begin
                        col_next = col_reg - COL_BITS'(1);
                    end
                end
                else if (!last_row)
                begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // The next element is fetched while the current one is compared.
    assign ram_re    = (state_next == ST_STEP);
    assign ram_raddr = {row_next, col_next};

    // Output register keeps the result apart from the walk.
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = pend_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        key_reg      <= key_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

endmodule

// ===== sv/sorted_matrix_staircase_search_unit.sv =====
// Write request: taken whenever the unit is idle; no result.
// Search request: k element reads of the staircase walk at one per cycle,
// k at most rows + cols - 1 (31 at 16 by 16), none for an empty matrix. Then
// the done state loads the result register once it is free, and the unit returns
// to idle to take the next request. The store's single read port sets the pace.
// Reset clears the sequencer and sets both counts to 16; the store is not
// cleared and holds unknown data until written.
module sorted_matrix_staircase_search_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  smss_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_stall,
    output smss_pkg::res_t res_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import smss_pkg::*;

    logic [CNT_BITS-1:0]   num_rows_reg, num_rows_next;
    logic [CNT_BITS-1:0]   num_cols_reg, num_cols_next;
    logic                  cfg_write;
    logic                  reg_index;
    dims_t                 dims;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Configuration port: registers are word aligned, index from paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_NUM_ROWS: num_rows_next = pwdata[CNT_BITS-1:0];
                REG_NUM_COLS: num_cols_next = pwdata[CNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb
    begin
        unique case (reg_index)
            REG_NUM_ROWS: prdata = 32'(num_rows_reg);
            REG_NUM_COLS: prdata = 32'(num_cols_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CNT_BITS'(16);
            num_cols_reg <= CNT_BITS'(16);
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    // Counts above the store size saturate.
    assign dims.rows = (num_rows_reg > MAX_ROWS_CNT) ? MAX_ROWS_CNT : num_rows_reg;
    assign dims.cols = (num_cols_reg > MAX_COLS_CNT) ? MAX_COLS_CNT : num_cols_reg;

    // Staircase walk sequencer with its compare unit.
    smss_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Matrix store, addressed by row and column.
    smss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
